### rtl/core/nsva_pkg.sv
// nsva_pkg: shared types and constants of the note stack voice allocator
// used by nsva_stack, nsva_voices and note_stack_voice_allocator
`timescale 1ns / 1ps
package nsva_pkg;

  // event codes
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // release order value of a busy voice, voice note of an unassigned voice
  localparam logic [7:0] FREE_MARK = 8'd255;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] note;
    logic [6:0] velocity;
  } in_t;

  typedef struct packed {
    logic [2:0] voice_index;
    logic [7:0] voice_note;
    logic       voice_gate;
    logic       last_voice;
    logic       reallocate;
    logic [4:0] note_count;
    logic [6:0] replay_note;
    logic [6:0] replay_velocity;
  } out_t;

  // note stack commands
  typedef struct packed {
    logic clear;
    logic shl;
    logic push;
  } stack_cmd_t;

  // voice table commands
  typedef struct packed {
    logic init;
    logic set_note;
    logic age;
    logic age_set;
    logic assign_voice;
  } voice_cmd_t;

endpackage

### rtl/core/nsva_stack.sv
// nsva_stack: newest-first note and velocity stack with held count
// depends on nsva_pkg for the command struct
`timescale 1ns / 1ps
module nsva_stack #(
  parameter int DEPTH = 16,
  parameter int AW = $clog2(DEPTH),
  parameter int HW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  nsva_pkg::stack_cmd_t cmd,
  input  logic [HW-1:0]      pos,
  input  logic [6:0]         push_note,
  input  logic [6:0]         push_vel,
  input  logic [AW-1:0]      rd_addr,
  output logic [6:0]         rd_note,
  output logic [6:0]         rd_vel,
  output logic [HW-1:0]      held
);

  logic [6:0] note_mem [DEPTH];
  logic [6:0] vel_mem  [DEPTH];

  // stack update: cleared on reset or clear, left shift from pos on removal, right shift on push
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        note_mem[i] <= 7'd0;
        vel_mem[i]  <= 7'd0;
      end
      held <= '0;
    end else if (cmd.shl) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (HW'(i) >= pos && HW'(i) < held) begin
          note_mem[i] <= note_mem[i+1];
          vel_mem[i]  <= vel_mem[i+1];
        end
      end
      if (HW'(DEPTH - 1) >= pos && HW'(DEPTH - 1) < held) begin
        note_mem[DEPTH-1] <= 7'd0;
        vel_mem[DEPTH-1]  <= 7'd0;
      end
      held <= held - HW'(1);
    end else if (cmd.push) begin
      for (int i = 1; i < DEPTH; i++) begin
        if (HW'(i) <= held) begin
          note_mem[i] <= note_mem[i-1];
          vel_mem[i]  <= vel_mem[i-1];
        end
      end
      note_mem[0] <= push_note;
      vel_mem[0]  <= push_vel;
      if (held < HW'(DEPTH)) begin
        held <= held + HW'(1);
      end
    end
  end

  // single read port
  assign rd_note = note_mem[rd_addr];
  assign rd_vel  = vel_mem[rd_addr];

endmodule

### rtl/core/nsva_voices.sv
// nsva_voices: voice note table and release order registers
// depends on nsva_pkg for the command struct and the free mark
`timescale 1ns / 1ps
module nsva_voices #(
  parameter int NV = 8,
  parameter int VW = (NV > 1) ? $clog2(NV) : 1,
  parameter int VCW = $clog2(NV + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nsva_pkg::voice_cmd_t cmd,
  input  logic [VCW-1:0]       vc,
  input  logic [VW-1:0]        widx,
  input  logic [7:0]           wnote,
  input  logic [6:0]           anote,
  input  logic [VW-1:0]        ridx,
  output logic [7:0]           rnote,
  output logic [7:0]           rro
);

  localparam int RST_VC = (NV < 4) ? NV : 4;

  logic [7:0] vnote [NV];
  logic [7:0] ro    [NV];
  logic [7:0] ro_aged [NV];

  // optional release of one voice, then ageing of every released voice among the active ones
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      logic [7:0] val;
      val = (cmd.age_set && VW'(i) == widx) ? 8'(vc) : ro[i];
      if (i < int'(vc) && val != 8'd0 && val <= 8'(vc)) begin
        ro_aged[i] = val - 8'd1;
      end else if (i < int'(vc)) begin
        ro_aged[i] = val;
      end else begin
        ro_aged[i] = ro[i];
      end
    end
  end

  // table update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NV; i++) begin
        vnote[i] <= nsva_pkg::FREE_MARK;
        ro[i]    <= (i < RST_VC) ? 8'(RST_VC - i) : 8'd0;
      end
    end else if (cmd.init) begin
      for (int i = 0; i < NV; i++) begin
        if (i < int'(vc)) begin
          vnote[i] <= nsva_pkg::FREE_MARK;
          ro[i]    <= 8'(int'(vc) - i);
        end
      end
    end else if (cmd.set_note) begin
      vnote[widx] <= wnote;
    end else if (cmd.age) begin
      for (int i = 0; i < NV; i++) begin
        ro[i] <= ro_aged[i];
      end
    end else if (cmd.assign_voice) begin
      ro[widx]    <= nsva_pkg::FREE_MARK;
      vnote[widx] <= {1'b0, anote};
    end
  end

  assign rnote = vnote[ridx];
  assign rro   = ro[ridx];

endmodule

### rtl/core/note_stack_voice_allocator.sv
// note_stack_voice_allocator: sequencer around the note stack and voice table, each with one read port
// flow: stack search, last-voice search, a release scan when the stack empties,
// an allocation scan on note on, then one result per voice per cycle while
// out_ready is high; throughput: one transaction at a time, and the stack search
// walks one slot a cycle and each voice scan one voice a cycle
// reset: synchronous, stacks empty, voice count 4, voices unassigned
// depends on nsva_pkg, nsva_stack and nsva_voices
`timescale 1ns / 1ps
module note_stack_voice_allocator #(
  parameter int STACK_DEPTH = 16,
  parameter int MAX_VOICES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  nsva_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output nsva_pkg::out_t out_data,
  input  logic           cfg_write,
  input  logic [3:0]     cfg_data
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int HW  = $clog2(STACK_DEPTH + 1);
  localparam int VCW = $clog2(MAX_VOICES + 1);
  localparam int VW  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FIND  = 4'd1;
  localparam logic [3:0] ST_SHL   = 4'd2;
  localparam logic [3:0] ST_VFIND = 4'd3;
  localparam logic [3:0] ST_VFIX  = 4'd4;
  localparam logic [3:0] ST_EMPTY = 4'd5;
  localparam logic [3:0] ST_PUSH  = 4'd6;
  localparam logic [3:0] ST_ASCAN = 4'd7;
  localparam logic [3:0] ST_AWR   = 4'd8;
  localparam logic [3:0] ST_CLR   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0]     state;
  logic [3:0]     voice_count;
  logic [1:0]     op;
  logic [6:0]     note;
  logic [6:0]     vel;
  logic [VCW-1:0] vc;
  logic [HW-1:0]  idx;
  logic [HW-1:0]  pos;
  logic [VW-1:0]  vidx;
  logic [VW-1:0]  w;
  logic           wfound;
  logic           flag;
  logic [VW-1:0]  u1;
  logic           u1f;
  logic [VW-1:0]  u2;
  logic           u2f;
  logic [7:0]     best;
  logic [VW-1:0]  bi;

  nsva_pkg::stack_cmd_t scmd;
  nsva_pkg::voice_cmd_t vcmd;
  logic [AW-1:0]  rd_addr;
  logic [6:0]     rd_note;
  logic [6:0]     rd_vel;
  logic [HW-1:0]  held;
  logic [VW-1:0]  widx;
  logic [7:0]     wnote;
  logic [7:0]     rnote;
  logic [7:0]     rro;
  logic [VCW-1:0] vc_clamped;
  logic [VW-1:0]  vc_last;
  logic           vc_lt_d;
  logic           vcm1_lt_d;
  logic           held_ge_vc;
  logic           target_ok;

  // clamp of the voice count register
  always_comb begin
    if (voice_count == 4'd0) begin
      vc_clamped = VCW'(1);
    end else if (int'(voice_count) > MAX_VOICES) begin
      vc_clamped = VCW'(MAX_VOICES);
    end else begin
      vc_clamped = VCW'(voice_count);
    end
  end

  assign vc_last    = VW'(vc - VCW'(1));
  assign vc_lt_d    = int'(vc) < STACK_DEPTH;
  assign vcm1_lt_d  = (int'(vc) - 1) < STACK_DEPTH;
  assign held_ge_vc = int'(held) >= int'(vc);
  assign target_ok  = (int'(held) > int'(vc)) && vc_lt_d;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_count <= 4'd4;
    end else if (cfg_write) begin
      voice_count <= cfg_data;
    end
  end

  nsva_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (scmd),
    .pos       (pos),
    .push_note (note),
    .push_vel  (vel),
    .rd_addr   (rd_addr),
    .rd_note   (rd_note),
    .rd_vel    (rd_vel),
    .held      (held)
  );

  nsva_voices #(.NV(MAX_VOICES)) u_voices (
    .clk   (clk),
    .rst   (rst),
    .cmd   (vcmd),
    .vc    (vc),
    .widx  (widx),
    .wnote (wnote),
    .anote (note),
    .ridx  (vidx),
    .rnote (rnote),
    .rro   (rro)
  );

  // commands and read address for the current step
  always_comb begin
    scmd    = '0;
    vcmd    = '0;
    rd_addr = AW'(vc);
    widx    = vidx;
    wnote   = 8'd0;
    unique case (state)
      ST_FIND: rd_addr = AW'(idx);
      ST_SHL:  scmd.shl = 1'b1;
      ST_VFIX: begin
        rd_addr = AW'(vc - VCW'(1));
        widx    = w;
        wnote   = vcm1_lt_d ? {1'b0, rd_note} : 8'd0;
        if (wfound && held_ge_vc) begin
          vcmd.set_note = 1'b1;
        end else if (wfound) begin
          vcmd.age     = 1'b1;
          vcmd.age_set = 1'b1;
        end
      end
      ST_EMPTY: begin
        if (rro == nsva_pkg::FREE_MARK) begin
          vcmd.age     = 1'b1;
          vcmd.age_set = 1'b1;
        end
      end
      ST_PUSH: scmd.push = 1'b1;
      ST_AWR: begin
        vcmd.assign_voice = 1'b1;
        widx = u2f ? u2 : (u1f ? u1 : bi);
      end
      ST_CLR: begin
        scmd.clear = 1'b1;
        vcmd.init  = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op   <= in_data.operation;
            note <= in_data.note;
            vel  <= in_data.velocity;
            vc   <= vc_clamped;
            idx  <= '0;
            vidx <= '0;
            flag <= 1'b0;
            wfound <= 1'b0;
            if (in_data.operation == nsva_pkg::OP_NOTE_ON ||
                in_data.operation == nsva_pkg::OP_NOTE_OFF) begin
              state <= ST_FIND;
            end else if (in_data.operation == nsva_pkg::OP_CLEAR) begin
              state <= ST_CLR;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        // search the stack for the event note
        ST_FIND: begin
          if (idx >= held) begin
            state <= ST_VFIND;
          end else if (rd_note == note) begin
            pos   <= idx;
            state <= ST_SHL;
          end else begin
            idx <= idx + HW'(1);
          end
        end
        ST_SHL: state <= ST_VFIND;
        // last voice holding the event note
        ST_VFIND: begin
          if (rnote == {1'b0, note}) begin
            w      <= vidx;
            wfound <= 1'b1;
          end
          if (vidx == vc_last) begin
            state <= ST_VFIX;
          end else begin
            vidx <= vidx + VW'(1);
          end
        end
        ST_VFIX: begin
          flag <= held_ge_vc;
          vidx <= '0;
          if (held == '0) begin
            state <= ST_EMPTY;
          end else if (op == nsva_pkg::OP_NOTE_ON) begin
            state <= ST_PUSH;
          end else begin
            state <= ST_OUT;
          end
        end
        // release every busy voice once the stack is empty
        ST_EMPTY: begin
          if (vidx == vc_last) begin
            vidx  <= '0;
            state <= (op == nsva_pkg::OP_NOTE_ON) ? ST_PUSH : ST_OUT;
          end else begin
            vidx <= vidx + VW'(1);
          end
        end
        ST_PUSH: begin
          vidx  <= '0;
          u1f   <= 1'b0;
          u2f   <= 1'b0;
          state <= ST_ASCAN;
        end
        // steal, reuse and least recent release in one voice scan
        ST_ASCAN: begin
          if (target_ok && rnote == {1'b0, rd_note}) begin
            u1  <= vidx;
            u1f <= 1'b1;
          end
          if (rnote == {1'b0, note}) begin
            u2  <= vidx;
            u2f <= 1'b1;
          end
          if (vidx == '0 || rro < best) begin
            best <= rro;
            bi   <= vidx;
          end
          if (vidx == vc_last) begin
            state <= ST_AWR;
          end else begin
            vidx <= vidx + VW'(1);
          end
        end
        ST_AWR: begin
          vidx  <= '0;
          state <= ST_OUT;
        end
        ST_CLR: begin
          vidx  <= '0;
          state <= ST_OUT;
        end
        // one result transaction per voice
        ST_OUT: begin
          if (out_ready) begin
            if (vidx == vc_last) begin
              state <= ST_IDLE;
            end else begin
              vidx <= vidx + VW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // result fields
  always_comb begin
    out_data.voice_index     = 3'(vidx);
    out_data.voice_note      = rnote;
    out_data.voice_gate      = (rro == nsva_pkg::FREE_MARK);
    out_data.last_voice      = (vidx == vc_last);
    out_data.reallocate      = flag;
    out_data.note_count      = 5'(held);
    out_data.replay_note     = vc_lt_d ? rd_note : 7'd0;
    out_data.replay_velocity = vc_lt_d ? rd_vel : 7'd0;
  end

  // no input transaction while results are pending
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input accepted while results pending");

  // held count never exceeds the stack depth
  a_held: assert property (@(posedge clk) disable iff (rst) int'(held) <= STACK_DEPTH)
    else $error("held count beyond stack depth");

  // last result transaction returns the block to idle
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_voice |=> in_ready)
    else $error("not idle after last result");

  // a push always leaves at least one held note
  a_push: assert property (@(posedge clk) disable iff (rst)
    state == ST_PUSH |=> held != '0)
    else $error("stack empty after push");

endmodule

### tb/nsva_checker.sv
// nsva_checker: watches the note stack voice allocator channels, predicts the
// per-voice results of each event and compares them; depends on nsva_pkg
`timescale 1ns / 1ps
module nsva_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  nsva_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  nsva_pkg::out_t out_data,
  input  logic           cfg_write,
  input  logic [3:0]     cfg_data,
  output int             fail_count,
  output int             pending,
  output int             event_count,
  output int             voice_result_count
);

  localparam int DEPTH = 16;
  localparam int VOICES = 8;

  logic [6:0]     held_notes [DEPTH];
  logic [6:0]     held_vels [DEPTH];
  int             held;
  logic [7:0]     voice_notes [VOICES];
  logic [7:0]     rel_order [VOICES];
  logic [3:0]     polyphony;
  nsva_pkg::out_t voice_results [$];

  function automatic int active_voices();
    if (polyphony == 0) return 1;
    if (polyphony > VOICES) return VOICES;
    return polyphony;
  endfunction

  function automatic void age_voices(int vc);
    for (int i = 0; i < vc; i++)
      if (rel_order[i] > 0 && rel_order[i] <= vc) rel_order[i]--;
  endfunction

  function automatic void clear_stack(int vc);
    for (int i = 0; i < vc; i++) begin
      voice_notes[i] = nsva_pkg::FREE_MARK;
      rel_order[i] = 8'(vc - i);
    end
    for (int i = 0; i < DEPTH; i++) begin
      held_notes[i] = '0;
      held_vels[i] = '0;
    end
    held = 0;
  endfunction

  // drop the note from the stack, hand its voice on or release it; empty stack releases busy voices
  function automatic bit drop_note(logic [6:0] n, int vc);
    int pos;
    int w;
    pos = -1;
    w = VOICES;
    for (int i = 0; i < held; i++)
      if (pos < 0 && held_notes[i] == n) pos = i;
    if (pos >= 0) begin
      for (int i = pos; i < held; i++) begin
        held_notes[i] = (i + 1 < DEPTH) ? held_notes[i + 1] : 7'd0;
        held_vels[i] = (i + 1 < DEPTH) ? held_vels[i + 1] : 7'd0;
      end
      held--;
    end
    for (int i = 0; i < vc; i++)
      if (voice_notes[i] == {1'b0, n}) w = i;
    if (w < vc) begin
      if (held >= vc) voice_notes[w] = {1'b0, held_notes[vc - 1]};
      else begin
        rel_order[w] = 8'(vc);
        age_voices(vc);
      end
    end
    if (held == 0)
      for (int i = 0; i < vc; i++)
        if (rel_order[i] == nsva_pkg::FREE_MARK) begin
          rel_order[i] = 8'(vc);
          age_voices(vc);
        end
    return held >= vc;
  endfunction

  // pick a voice: same note, else pushed-out note, else least recently released (lowest index on a tie)
  function automatic void pick_voice(logic [6:0] n, int vc);
    int sel;
    logic [7:0] lowest;
    sel = VOICES;
    lowest = nsva_pkg::FREE_MARK;
    if (held > vc && vc < DEPTH)
      for (int i = 0; i < vc; i++)
        if (voice_notes[i] == {1'b0, held_notes[vc]}) sel = i;
    for (int i = 0; i < vc; i++)
      if (voice_notes[i] == {1'b0, n}) sel = i;
    if (sel >= vc) begin
      for (int i = 0; i < vc; i++)
        if (rel_order[i] < lowest) lowest = rel_order[i];
      for (int i = vc - 1; i >= 0; i--)
        if (rel_order[i] == lowest) sel = i;
    end
    if (sel < vc) begin
      rel_order[sel] = nsva_pkg::FREE_MARK;
      voice_notes[sel] = {1'b0, n};
    end
  endfunction

  function automatic bit press_note(logic [6:0] n, logic [6:0] vel, int vc);
    bit flag;
    int top;
    flag = drop_note(n, vc);
    top = (held < DEPTH - 1) ? held : DEPTH - 1;
    for (int i = top; i > 0; i--) begin
      held_notes[i] = held_notes[i - 1];
      held_vels[i] = held_vels[i - 1];
    end
    if (held < DEPTH) held++;
    held_notes[0] = n;
    held_vels[0] = vel;
    pick_voice(n, vc);
    return flag;
  endfunction

  // apply one event and queue one expected result per voice
  function automatic void apply_event(nsva_pkg::in_t ev);
    int vc;
    bit flag;
    nsva_pkg::out_t r;
    vc = active_voices();
    flag = 0;
    case (ev.operation)
      nsva_pkg::OP_NOTE_ON:  flag = press_note(ev.note, ev.velocity, vc);
      nsva_pkg::OP_NOTE_OFF: flag = drop_note(ev.note, vc);
      nsva_pkg::OP_CLEAR:    clear_stack(vc);
      default: ;
    endcase
    for (int v = 0; v < vc; v++) begin
      r.voice_index = 3'(v);
      r.voice_note = voice_notes[v];
      r.voice_gate = rel_order[v] == nsva_pkg::FREE_MARK;
      r.last_voice = v == vc - 1;
      r.reallocate = flag;
      r.note_count = 5'(held);
      r.replay_note = (vc < DEPTH) ? held_notes[vc] : 7'd0;
      r.replay_velocity = (vc < DEPTH) ? held_vels[vc] : 7'd0;
      voice_results.push_back(r);
    end
  endfunction

  // compare results, then take in new events and register writes
  always @(posedge clk) begin
    nsva_pkg::out_t want;
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        voice_notes[i] = nsva_pkg::FREE_MARK;
        rel_order[i] = '0;
      end
      polyphony = 4'd4;
      clear_stack(4);
      voice_results.delete();
      fail_count <= 0;
      event_count <= 0;
      voice_result_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        voice_result_count <= voice_result_count + 1;
        if (voice_results.size() == 0) begin
          $error("voice result with nothing expected: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = voice_results.pop_front();
          if (out_data !== want) begin
            fail_count <= fail_count + 1;
            if (out_data.voice_index !== want.voice_index)
              $error("voice_index exp %0d got %0d", want.voice_index, out_data.voice_index);
            if (out_data.voice_note !== want.voice_note)
              $error("voice_note exp %0d got %0d", want.voice_note, out_data.voice_note);
            if (out_data.voice_gate !== want.voice_gate)
              $error("voice_gate exp %0d got %0d", want.voice_gate, out_data.voice_gate);
            if (out_data.last_voice !== want.last_voice)
              $error("last_voice exp %0d got %0d", want.last_voice, out_data.last_voice);
            if (out_data.reallocate !== want.reallocate)
              $error("reallocate exp %0d got %0d", want.reallocate, out_data.reallocate);
            if (out_data.note_count !== want.note_count)
              $error("note_count exp %0d got %0d", want.note_count, out_data.note_count);
            if (out_data.replay_note !== want.replay_note)
              $error("replay_note exp %0d got %0d", want.replay_note, out_data.replay_note);
            if (out_data.replay_velocity !== want.replay_velocity)
              $error("replay_velocity exp %0d got %0d", want.replay_velocity,
                     out_data.replay_velocity);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_event(in_data);
        event_count <= event_count + 1;
      end
      if (cfg_write) polyphony = cfg_data;
    end
    pending <= voice_results.size();
  end

endmodule

### tb/testbench.sv
// testbench: drives events and voice count writes into note_stack_voice_allocator
// depends on nsva_pkg, the allocator rtl and nsva_checker
`timescale 1ns / 1ps
module testbench;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  nsva_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  nsva_pkg::out_t out_data;
  logic cfg_write;
  logic [3:0] cfg_data;
  int   fail_count;
  int   pending;
  int   event_count;
  int   voice_result_count;
  int   hold_req;
  int   idle_cycles;

  note_stack_voice_allocator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  nsva_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .event_count(event_count), .voice_result_count(voice_result_count)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver stalls on its own cycle pattern, with one long hold-off on request
  initial begin
    int phase;
    int hold_seen;
    phase = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if ((phase / 64) % 4 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("FAIL note_stack_voice_allocator");
      $finish;
    end
  end

  // offer one event and hold it until accepted; called at a falling edge
  task automatic send_event(logic [1:0] op, logic [6:0] n, logic [6:0] vel);
    in_data <= '{operation: op, note: n, velocity: vel};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // random gap after a burst
  task automatic maybe_gap();
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk);
    end
  endtask

  // let every result drain and the block settle before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic set_voices(logic [3:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // mostly a small note pool so notes repeat, stack fills and voices are stolen
  task automatic random_event();
    int pick;
    logic [6:0] n;
    pick = $urandom_range(0, 99);
    n = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(40, 63));
    if (pick < 66) send_event(nsva_pkg::OP_NOTE_ON, n, 7'($urandom_range(0, 127)));
    else if (pick < 96) send_event(nsva_pkg::OP_NOTE_OFF, n, 7'($urandom_range(0, 127)));
    else if (pick < 98) send_event(nsva_pkg::OP_CLEAR, n, 7'($urandom_range(0, 127)));
    else send_event(2'd3, n, 7'($urandom_range(0, 127)));
    maybe_gap();
  endtask

  initial begin
    logic [3:0] settings [7];
    settings = '{4'd8, 4'd15, 4'd1, 4'd3, 4'd6, 4'd2, 4'd5};
    hold_req = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, every operation, repeats and releases
    send_event(nsva_pkg::OP_NOTE_ON, 7'd0, 7'd0);
    send_event(nsva_pkg::OP_NOTE_ON, 7'd127, 7'd127);
    send_event(nsva_pkg::OP_NOTE_ON, 7'd60, 7'd85);
    send_event(nsva_pkg::OP_NOTE_ON, 7'd0, 7'd42);
    send_event(nsva_pkg::OP_NOTE_OFF, 7'd99, 7'd0);
    send_event(2'd3, 7'd127, 7'd127);
    send_event(nsva_pkg::OP_NOTE_ON, 7'd61, 7'd1);
    send_event(nsva_pkg::OP_NOTE_ON, 7'd62, 7'd2);
    send_event(nsva_pkg::OP_NOTE_OFF, 7'd127, 7'd0);
    send_event(nsva_pkg::OP_NOTE_OFF, 7'd0, 7'd0);
    send_event(nsva_pkg::OP_NOTE_OFF, 7'd60, 7'd0);
    send_event(nsva_pkg::OP_NOTE_OFF, 7'd61, 7'd0);
    send_event(nsva_pkg::OP_NOTE_OFF, 7'd62, 7'd0);
    send_event(nsva_pkg::OP_NOTE_ON, 7'd85, 7'd127);
    send_event(nsva_pkg::OP_CLEAR, 7'd0, 7'd0);

    // zero acts as one voice
    set_voices(4'd0);
    send_event(nsva_pkg::OP_NOTE_ON, 7'd10, 7'd10);
    send_event(nsva_pkg::OP_NOTE_ON, 7'd11, 7'd11);
    send_event(nsva_pkg::OP_NOTE_OFF, 7'd11, 7'd0);
    send_event(nsva_pkg::OP_NOTE_OFF, 7'd10, 7'd0);
    for (int i = 0; i < 18; i++) send_event(nsva_pkg::OP_NOTE_ON, 7'(20 + i), 7'(i * 7));

    // random phases at several voice counts
    for (int p = 0; p < 7; p++) begin
      set_voices(settings[p]);
      for (int i = 0; i < 55; i++) begin
        random_event();
        if (p == 2 && i == 10) begin
          hold_req++;
          for (int k = 0; k < 20; k++)
            send_event(nsva_pkg::OP_NOTE_ON, 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)));
        end
        if (i == 30) begin
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end
    set_voices(4'd4);
    for (int i = 0; i < 25; i++) random_event();

    drain();
    $display("covered %0d events and %0d voice results over voice counts 0 to 15",
             event_count, voice_result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS note_stack_voice_allocator");
    end else begin
      $display("FAIL note_stack_voice_allocator");
    end
    $finish;
  end

endmodule
